FILE: rtl/core/pbf_pkg.sv
// shared constants, register indexes and types of the palette blit core
package pbf_pkg;

    // palette geometry
    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_IDX_BITS  = $clog2(PALETTE_DEPTH);

    // rectangle walk counter width
    localparam int COORD_BITS = 11;

    // fixed field widths
    localparam int DIM_BITS      = 12;
    localparam int POS_BITS      = 11;
    localparam int SLOT_BITS     = 8;
    localparam int INDEX_BITS    = 8;
    localparam int COLOR_BITS    = 32;
    localparam int ADDR_BITS     = 22;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 12;

    // derived address arithmetic widths
    localparam int XY_BITS   = ((COORD_BITS > POS_BITS) ? COORD_BITS : POS_BITS) + 1;
    localparam int PROD_BITS = DIM_BITS + XY_BITS;
    localparam int FULL_BITS = PROD_BITS + 1;
    localparam int AREA_BITS = 2 * DIM_BITS;

    // decoupling queue
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_INFLIGHT = QUEUE_DEPTH + 2;

    // register reset values
    localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RST  = DIM_BITS'(720);
    localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RST = DIM_BITS'(576);

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_X     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Y     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_RECT_LEFT    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_RECT_RIGHT   = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_RECT_TOP     = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_RECT_BOTTOM  = 3'd7;

    // request kinds
    localparam logic REQ_PALETTE = 1'b0;
    localparam logic REQ_PIXEL   = 1'b1;

    // frame size seen by the back end
    typedef struct packed {
        logic [DIM_BITS-1:0] width;
        logic [DIM_BITS-1:0] height;
    } frame_cfg_t;

    // classified word passed from front to back
    typedef struct packed {
        logic                    is_pixel;
        logic [SLOT_BITS-1:0]    slot;
        logic [COLOR_BITS-1:0]   color;
        logic [PAL_IDX_BITS-1:0] pal_idx;
        logic [XY_BITS-1:0]      x;
        logic [XY_BITS-1:0]      field_line;
        logic                    done;
    } blit_entry_t;

endpackage

FILE: rtl/core/pbf_req_if.sv
// request channel: palette loads and pixel indices
interface pbf_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [pbf_pkg::SLOT_BITS-1:0]  palette_slot;
    logic [pbf_pkg::COLOR_BITS-1:0] palette_color;
    logic [pbf_pkg::INDEX_BITS-1:0] pixel_index;

    modport source (output valid, req_type, palette_slot, palette_color, pixel_index,
                    input ready);
    modport sink   (input valid, req_type, palette_slot, palette_color, pixel_index,
                    output ready);
    modport mon    (input valid, ready, req_type, palette_slot, palette_color,
                    pixel_index);
endinterface

FILE: rtl/core/pbf_fb_if.sv
// framebuffer write channel
interface pbf_fb_if;
    logic                          valid;
    logic                          ready;
    logic [pbf_pkg::ADDR_BITS-1:0]  fb_address;
    logic [pbf_pkg::COLOR_BITS-1:0] fb_pixel;
    logic                          rect_done;
    logic                          out_of_range;

    modport source (output valid, fb_address, fb_pixel, rect_done, out_of_range,
                    input ready);
    modport sink   (input valid, fb_address, fb_pixel, rect_done, out_of_range,
                    output ready);
    modport mon    (input valid, ready, fb_address, fb_pixel, rect_done, out_of_range);
endinterface

FILE: rtl/core/pbf_front.sv
// front end: register file, rectangle walk and word classification
module pbf_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [pbf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [pbf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    pbf_req_if.sink                            req_ch,
    output logic                               push_valid,
    input  logic                               push_ready,
    output pbf_pkg::blit_entry_t               push_data,
    output pbf_pkg::frame_cfg_t                frame_cfg
);
    import pbf_pkg::*;

    logic [DIM_BITS-1:0]   frame_width_reg, frame_height_reg;
    logic [POS_BITS-1:0]   origin_x_reg, origin_y_reg;
    logic [POS_BITS-1:0]   rect_left_reg, rect_right_reg, rect_top_reg, rect_bottom_reg;
    logic [COORD_BITS-1:0] column_reg, column_next;
    logic [COORD_BITS-1:0] line_reg, line_next;

    logic [COORD_BITS-1:0] left_c, right_c, top_c, bottom_c;
    logic [COORD_BITS-1:0] restart_col, restart_line;
    logic                  row_end, col_end, done;
    logic                  accept;
    logic [XY_BITS-1:0]    x_pos, y_pos, field_line;

    assign frame_cfg.width  = frame_width_reg;
    assign frame_cfg.height = frame_height_reg;

    // bounds taken at counter width
    assign left_c   = COORD_BITS'(rect_left_reg);
    assign right_c  = COORD_BITS'(rect_right_reg);
    assign top_c    = COORD_BITS'(rect_top_reg);
    assign bottom_c = COORD_BITS'(rect_bottom_reg);

    // walk start after a register write, taking a bound written in the same cycle
    assign restart_col  = (cfg_index == REG_RECT_LEFT)
                        ? COORD_BITS'(cfg_data[POS_BITS-1:0]) : left_c;
    assign restart_line = (cfg_index == REG_RECT_TOP)
                        ? COORD_BITS'(cfg_data[POS_BITS-1:0]) : top_c;

    assign accept          = req_ch.valid && push_ready;
    assign req_ch.ready    = push_ready;
    assign push_valid      = req_ch.valid;

    // walk position and end-of-line / end-of-rectangle tests
    assign row_end = column_reg >= right_c;
    assign col_end = line_reg >= bottom_c;
    assign done    = row_end && col_end;

    // screen position and field-split line
    assign x_pos = XY_BITS'(origin_x_reg) + XY_BITS'(column_reg);
    assign y_pos = XY_BITS'(origin_y_reg) + XY_BITS'(line_reg);
    assign field_line = y_pos[0]
                      ? XY_BITS'(frame_height_reg >> 1) + XY_BITS'(y_pos >> 1)
                      : XY_BITS'(y_pos >> 1);

    // word handed to the queue
    always_comb
    begin
        push_data.is_pixel   = (req_ch.req_type == REQ_PIXEL);
        push_data.slot       = req_ch.palette_slot;
        push_data.color      = req_ch.palette_color;
        push_data.pal_idx    = PAL_IDX_BITS'(req_ch.pixel_index % PALETTE_DEPTH);
        push_data.x          = x_pos;
        push_data.field_line = field_line;
        push_data.done       = done;
    end

    // counter next state
    always_comb
    begin
        column_next = column_reg;
        line_next   = line_reg;
        priority if (cfg_we)
        begin
            column_next = restart_col;
            line_next   = restart_line;
        end
        else if (accept && req_ch.req_type == REQ_PIXEL)
        begin
            priority if (done)
            begin
                column_next = left_c;
                line_next   = top_c;
            end
            else if (row_end)
            begin
                column_next = left_c;
                line_next   = line_reg + 1'b1;
            end
            else
            begin
                column_next = column_reg + 1'b1;
            end
        end
    end

    // walk counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            line_reg   <= '0;
        end
        else
        begin
            column_reg <= column_next;
            line_reg   <= line_next;
        end
    end

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            rect_left_reg    <= '0;
            rect_right_reg   <= '0;
            rect_top_reg     <= '0;
            rect_bottom_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                REG_ORIGIN_X:     origin_x_reg     <= POS_BITS'(cfg_data);
                REG_ORIGIN_Y:     origin_y_reg     <= POS_BITS'(cfg_data);
                REG_RECT_LEFT:    rect_left_reg    <= POS_BITS'(cfg_data);
                REG_RECT_RIGHT:   rect_right_reg   <= POS_BITS'(cfg_data);
                REG_RECT_TOP:     rect_top_reg     <= POS_BITS'(cfg_data);
                REG_RECT_BOTTOM:  rect_bottom_reg  <= POS_BITS'(cfg_data);
                default:          frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

endmodule

FILE: rtl/core/pbf_queue.sv
// short queue between front and back end
module pbf_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  pbf_pkg::blit_entry_t push_data,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output pbf_pkg::blit_entry_t pop_data
);
    import pbf_pkg::*;

    blit_entry_t          slots_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;
    logic                 do_push, do_pop;

    assign push_ready = (count_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: rtl/core/pbf_back.sv
// back end: palette memory, address multiply and framebuffer word register
module pbf_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pbf_pkg::frame_cfg_t  frame_cfg,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  pbf_pkg::blit_entry_t pop_data,
    pbf_fb_if.source             fb_ch
);
    import pbf_pkg::*;

    logic [COLOR_BITS-1:0] pal_mem [PALETTE_DEPTH];

    logic                  s1_valid_reg, s1_valid_next;
    logic [COLOR_BITS-1:0] s1_pixel_reg;
    logic [PROD_BITS-1:0]  s1_prod_reg;
    logic [XY_BITS-1:0]    s1_x_reg;
    logic                  s1_done_reg;
    logic [AREA_BITS-1:0]  area_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [ADDR_BITS-1:0]  out_addr_reg;
    logic [COLOR_BITS-1:0] out_pixel_reg;
    logic                  out_done_reg;
    logic                  out_oor_reg;

    logic                  s2_load, s1_load, do_pop, pix_pop, pal_write;
    logic [FULL_BITS-1:0]  full_addr;

    assign s2_load   = !out_valid_reg || fb_ch.ready;
    assign s1_load   = !s1_valid_reg || s2_load;
    assign pop_ready = s1_load;
    assign do_pop    = pop_valid && s1_load;
    assign pix_pop   = do_pop && pop_data.is_pixel;
    assign pal_write = do_pop && !pop_data.is_pixel
                       && (32'(pop_data.slot) < PALETTE_DEPTH);

    assign s1_valid_next  = s1_load ? pix_pop : s1_valid_reg;
    assign out_valid_next = s2_load ? s1_valid_reg : out_valid_reg;

    // full address, tested against the frame area in the word register
    assign full_addr = FULL_BITS'(s1_prod_reg) + FULL_BITS'(s1_x_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // palette memory with registered read
    always_ff @(posedge clk)
    begin
        if (pal_write)
            pal_mem[PAL_IDX_BITS'(pop_data.slot)] <= pop_data.color;
        if (pix_pop)
            s1_pixel_reg <= pal_mem[pop_data.pal_idx];
    end

    // line offset multiply
    always_ff @(posedge clk)
    begin
        if (pix_pop)
        begin
            s1_prod_reg <= PROD_BITS'(pop_data.field_line) * PROD_BITS'(frame_cfg.width);
            s1_x_reg    <= pop_data.x;
            s1_done_reg <= pop_data.done;
        end
        area_reg <= AREA_BITS'(frame_cfg.width) * AREA_BITS'(frame_cfg.height);
    end

    // framebuffer word register
    always_ff @(posedge clk)
    begin
        if (s2_load && s1_valid_reg)
        begin
            out_addr_reg  <= ADDR_BITS'(full_addr);
            out_pixel_reg <= s1_pixel_reg;
            out_done_reg  <= s1_done_reg;
            out_oor_reg   <= (full_addr >= FULL_BITS'(area_reg));
        end
    end

    assign fb_ch.valid        = out_valid_reg;
    assign fb_ch.fb_address   = out_addr_reg;
    assign fb_ch.fb_pixel     = out_pixel_reg;
    assign fb_ch.rect_done    = out_done_reg;
    assign fb_ch.out_of_range = out_oor_reg;

endmodule

FILE: rtl/core/palette_blit_to_field_split_framebuffer_core.sv
// top level of the palette blit core: front end, queue and back end
// pixel words pass from req_ch via queue, lookup stage and word register to fb_ch
// throughput: one word per cycle, palette loads and pixels alike, queue not full
// palette loads give no framebuffer word; the queue holds up to four words
// reset: registers go to 720 x 576 with zero origin and rectangle, walk restarts,
// queue and stages empty; palette contents are undefined until loaded
module palette_blit_to_field_split_framebuffer_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [pbf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [pbf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    pbf_req_if.sink                            req_ch,
    pbf_fb_if.source                           fb_ch
);
    import pbf_pkg::*;

    logic        push_valid, push_ready, pop_valid, pop_ready;
    blit_entry_t push_data, pop_data;
    frame_cfg_t  frame_cfg;

    // classify and walk
    pbf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_ch     (req_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .frame_cfg  (frame_cfg)
    );

    // decoupling
    pbf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // look up and address
    pbf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame_cfg (frame_cfg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .fb_ch     (fb_ch)
    );

endmodule

FILE: rtl/core/pbf_checker.sv
// port-level checks on the palette blit core and their binding
module pbf_checker (
    input logic       clk,
    input logic       rst_n,
    pbf_req_if.sink   req_ch,
    pbf_fb_if.source  fb_ch
);
    import pbf_pkg::*;

    logic [3:0] pending_reg, pending_next;
    logic       pix_in, word_out;

    assign pix_in   = req_ch.valid && req_ch.ready && (req_ch.req_type == REQ_PIXEL);
    assign word_out = fb_ch.valid && fb_ch.ready;

    // pixels accepted but not yet delivered
    always_comb
    begin
        pending_next = pending_reg;
        if (pix_in && !word_out)
            pending_next = pending_reg + 1'b1;
        else if (word_out && !pix_in)
            pending_next = pending_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    // a stalled word holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fb_ch.valid && !fb_ch.ready |=> fb_ch.valid && $stable(fb_ch.fb_address)
            && $stable(fb_ch.fb_pixel) && $stable(fb_ch.rect_done)
            && $stable(fb_ch.out_of_range))
        else $error("framebuffer word changed while stalled");

    // no word without a pixel behind it
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        word_out |-> pending_reg != '0)
        else $error("framebuffer word without an accepted pixel");

    // in-flight pixels bounded by queue and stage capacity
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 4'(MAX_INFLIGHT))
        else $error("more pixels in flight than the core can hold");

    // empty and ready right out of reset
    a_reset_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> req_ch.ready && !fb_ch.valid)
        else $error("core not empty after reset");

endmodule

bind palette_blit_to_field_split_framebuffer_core pbf_checker u_pbf_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .req_ch (req_ch),
    .fb_ch  (fb_ch)
);
